// ----- hw/rtl/bbc_pkg.sv -----
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the bright spot box center unit
// Word layouts of the pixel and result channels, coordinate widths and
// reset values of the threshold and the box edges.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned COORD_W = 11;

    // Frame limits; a pixel at or beyond them is never bright.
    localparam int unsigned MAX_WIDTH  = 2048;
    localparam int unsigned MAX_HEIGHT = 2048;

    localparam logic [PIX_W-1:0]   THRESH_RESET = PIX_W'(200);
    localparam logic [COORD_W-1:0] EDGE_LOW_RESET  = '1;
    localparam logic [COORD_W-1:0] EDGE_HIGH_RESET = '0;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [PIX_W-1:0] green_value;
        coord_t           col_index;
        coord_t           row_index;
        logic             frame_last;
    } pixel_t;

    typedef struct packed {
        coord_t center_x;
        coord_t center_y;
        logic   spot_found;
    } result_t;

endpackage : bbc_pkg

`default_nettype wire

// ----- hw/rtl/bbc_box_track.sv -----
// ----------------------------------------------------------------------------
// bbc_box_track: running bounding box and center of the bright pixels
// Updates the box edges on every stepped pixel; on the frame's last pixel
// presents the center of the updated box and clears the box.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_box_track (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire bbc_pkg::pixel_t  pix,
    input  wire logic [bbc_pkg::PIX_W-1:0] threshold,
    output bbc_pkg::result_t      center
);
    import bbc_pkg::*;

    coord_t left_reg,   left_next;
    coord_t right_reg,  right_next;
    coord_t top_reg,    top_next;
    coord_t bottom_reg, bottom_next;
    logic   seen_reg,   seen_next;

    coord_t left_upd, right_upd, top_upd, bottom_upd;
    logic   seen_upd;
    logic   bright;
    coord_t span_x, span_y;

    always_comb
    begin
        bright = (pix.green_value > threshold) &&
                 (32'(pix.col_index) < MAX_WIDTH) &&
                 (32'(pix.row_index) < MAX_HEIGHT);

        left_upd   = left_reg;
        right_upd  = right_reg;
        top_upd    = top_reg;
        bottom_upd = bottom_reg;
        seen_upd   = seen_reg;
        if (bright)
        begin
            if (pix.col_index < left_reg)   left_upd   = pix.col_index;
            if (pix.col_index > right_reg)  right_upd  = pix.col_index;
            if (pix.row_index < top_reg)    top_upd    = pix.row_index;
            if (pix.row_index > bottom_reg) bottom_upd = pix.row_index;
            seen_upd = 1'b1;
        end

        // lo <= hi whenever a bright pixel was seen
        span_x = right_upd - left_upd;
        span_y = bottom_upd - top_upd;
        if (seen_upd)
        begin
            center.center_x   = left_upd + (span_x >> 1);
            center.center_y   = top_upd + (span_y >> 1);
            center.spot_found = 1'b1;
        end
        else
        begin
            center.center_x   = '0;
            center.center_y   = '0;
            center.spot_found = 1'b0;
        end

        left_next   = left_reg;
        right_next  = right_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        seen_next   = seen_reg;
        if (step)
        begin
            if (pix.frame_last)
            begin
                left_next   = EDGE_LOW_RESET;
                right_next  = EDGE_HIGH_RESET;
                top_next    = EDGE_LOW_RESET;
                bottom_next = EDGE_HIGH_RESET;
                seen_next   = 1'b0;
            end
            else
            begin
                left_next   = left_upd;
                right_next  = right_upd;
                top_next    = top_upd;
                bottom_next = bottom_upd;
                seen_next   = seen_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= EDGE_LOW_RESET;
            right_reg  <= EDGE_HIGH_RESET;
            top_reg    <= EDGE_LOW_RESET;
            bottom_reg <= EDGE_HIGH_RESET;
            seen_reg   <= 1'b0;
        end
        else
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
            seen_reg   <= seen_next;
        end
    end

    // box is well formed once a bright pixel is in it
    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> (left_reg <= right_reg) && (top_reg <= bottom_reg))
        else $error("bounding box edges out of order");

    // empty box sits at its cleared values
    a_box_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> (left_reg == EDGE_LOW_RESET) && (right_reg == EDGE_HIGH_RESET) &&
                      (top_reg == EDGE_LOW_RESET) && (bottom_reg == EDGE_HIGH_RESET))
        else $error("empty box not at cleared values");

    // a stepped last pixel always leaves the box empty
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && pix.frame_last |=> !seen_reg)
        else $error("box not cleared after end of frame");

endmodule : bbc_box_track

`default_nettype wire

// ----- hw/rtl/bright_spot_bbox_center_unit.sv -----
// ----------------------------------------------------------------------------
// bright_spot_bbox_center_unit: center of the bright spot per frame
// Tracks the bounding box of pixels above a threshold over a raster stream
// and emits the box center once per frame.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : valid/ready channel, one word per pixel (green, column, row,
//            end-of-frame flag). A word per cycle, unless a last pixel stalls.
//   result : valid/ready channel, one word per frame, produced by the pixel
//            whose frame_last is set: box center (min + span/2, rounded
//            down) and spot_found. With no bright pixel the center is 0,0.
//   cfg    : valid/ready write channel for bright_threshold (8 bits); always
//            ready. Write only while no pixel is in flight.
//   Path   : a pixel is registered in the input register; the box update
//            and center are one short compare/add path into the result
//            register, from which the result is presented. Throughput is
//            one pixel per cycle while no last pixel is stalled.
//   Stall  : while the result register is held, pixels without frame_last
//            keep flowing; a last pixel waits in the input register and
//            pixel_ready drops until the pending result is taken.
//   Reset  : threshold returns to 200, the box is cleared, no result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bright_spot_bbox_center_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // pixel stream
    input  wire logic                        pixel_valid,
    output logic                             pixel_ready,
    input  wire bbc_pkg::pixel_t             pixel,
    // per-frame result
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output bbc_pkg::result_t                 result,
    // threshold write
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [bbc_pkg::PIX_W-1:0]   cfg_data
);
    import bbc_pkg::*;

    // threshold register
    logic [PIX_W-1:0] thresh_reg, thresh_next;

    // input register
    logic    in_valid_reg, in_valid_next;
    pixel_t  in_pix_reg,   in_pix_next;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg,       out_next;

    result_t center;
    logic    out_free;     // result register can take a word this cycle
    logic    advance;      // input register word moves through the tracker
    logic    load_out;

    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        out_free    = !out_valid_reg || result_ready;
        // only a last pixel needs room in the result register
        advance     = in_valid_reg && (!in_pix_reg.frame_last || out_free);
        load_out    = advance && in_pix_reg.frame_last;
        pixel_ready = !in_valid_reg || advance;

        thresh_next = (cfg_valid && cfg_ready) ? cfg_data : thresh_reg;

        in_valid_next = in_valid_reg;
        in_pix_next   = in_pix_reg;
        if (pixel_ready)
        begin
            in_valid_next = pixel_valid;
            in_pix_next   = pixel;
        end

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_next       = center;
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    bbc_box_track u_box (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .pix       (in_pix_reg),
        .threshold (thresh_reg),
        .center    (center)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= THRESH_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            thresh_reg    <= thresh_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        in_pix_reg <= in_pix_next;
        out_reg    <= out_next;
    end

    // no spot means a zero center
    a_empty_center: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.spot_found |-> (result.center_x == '0) &&
                                               (result.center_y == '0))
        else $error("center nonzero without a spot");

    // a last pixel blocked by a held result stalls the input
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_pix_reg.frame_last && result_valid && !result_ready
        |-> !pixel_ready)
        else $error("input not stalled behind pending result");

    // a last pixel moving on always lands in the result register
    a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_pix_reg.frame_last |=> result_valid)
        else $error("frame end produced no result");

endmodule : bright_spot_bbox_center_unit

`default_nettype wire
